@@ hdl/mse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants for the Microwire serial EEPROM
// Defaults, pin command codes, opcodes and the control structs that pass
// between the top level and the protocol controller.
// ----------------------------------------------------------------------------
package mse_pkg;

  parameter int DEFAULT_ADDR_BITS     = 7;
  parameter int DEFAULT_CMD_ADDR_BITS = 7;
  parameter int DEFAULT_DEPTH         = 128;

  parameter int LOAD_ADDR_W = 7;
  parameter int BYTE_W      = 8;

  parameter logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  // Opcode field and the sub-codes carried in the top two address bits
  parameter logic [1:0] OPC_EXT     = 2'b00;
  parameter logic [1:0] OPC_WRITE_A = 2'b01;
  parameter logic [1:0] OPC_READ    = 2'b10;
  parameter logic [1:0] OPC_WRITE_B = 2'b11;
  parameter logic [1:0] SUB_LOCK    = 2'b00;
  parameter logic [1:0] SUB_INVALID = 2'b01;
  parameter logic [1:0] SUB_ERASE   = 2'b10;
  parameter logic [1:0] SUB_UNLOCK  = 2'b11;

  typedef enum logic [1:0] {
    CMD_DATA_IN     = 2'd0,
    CMD_CHIP_SELECT = 2'd1,
    CMD_CLOCK       = 2'd2,
    CMD_PRELOAD     = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                   command;
    logic                   pin_level;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [BYTE_W-1:0]      load_data;
  } item_t;

  typedef struct packed {
    logic go;     // input transaction accepted this cycle
    logic taken;  // pending result moved into the output register
  } ctrl_req_t;

  typedef struct packed {
    logic idle;         // free to take the next item
    logic res_pending;  // result of the last item is ready
    logic dout;         // data-out pin level after the last item
  } ctrl_status_t;

endpackage

@@ hdl/mse_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_store: byte store of the EEPROM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module mse_store #(
  parameter int DEPTH = mse_pkg::DEFAULT_DEPTH
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  logic [mse_pkg::BYTE_W-1:0]      wr_data,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic [mse_pkg::BYTE_W-1:0]      rd_data
);

  logic [mse_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/mse_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_ctrl: Microwire protocol controller
// Tracks pin levels, decodes edges, runs the command phases and drives the
// byte store: fetch on read, write-back on write, fill sweep on erase/reset.
// ----------------------------------------------------------------------------
module mse_ctrl #(
  parameter int ADDR_BITS     = mse_pkg::DEFAULT_ADDR_BITS,
  parameter int CMD_ADDR_BITS = mse_pkg::DEFAULT_CMD_ADDR_BITS,
  parameter int DEPTH         = mse_pkg::DEFAULT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mse_pkg::item_t                  item,
  input  mse_pkg::ctrl_req_t              req,
  output mse_pkg::ctrl_status_t           status,
  output logic                            mem_we,
  output logic [$clog2(DEPTH)-1:0]        mem_waddr,
  output logic [mse_pkg::BYTE_W-1:0]      mem_wdata,
  output logic [$clog2(DEPTH)-1:0]        mem_raddr,
  input  logic [mse_pkg::BYTE_W-1:0]      mem_rdata
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(CMD_ADDR_BITS + 2);
  localparam int SHIFT_W = CMD_ADDR_BITS + 2;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CMD_LAST  = CNT_W'(CMD_ADDR_BITS + 1);
  localparam logic [CNT_W-1:0] BYTE_LAST = CNT_W'(7);

  typedef enum logic [1:0] {SEQ_CLEAR, SEQ_IDLE, SEQ_LOAD} seq_t;
  typedef enum logic [2:0] {
    PH_RESET, PH_START, PH_CMD, PH_READ, PH_DATA, PH_DONE
  } phase_t;

  seq_t                       seq;
  phase_t                     phase;
  logic                       cs_level;
  logic                       clk_level;
  logic                       din_level;
  logic                       locked;
  logic                       res_pending;
  logic [CNT_W-1:0]           bit_counter;
  logic [SHIFT_W-1:0]         op_shift;
  logic [mse_pkg::BYTE_W-1:0] data_shift;
  logic [ADDR_BITS-1:0]       cur_addr;
  logic [IDX_W-1:0]           clr_idx;

  logic                       cs_rise;
  logic                       cs_fall;
  logic                       clk_rise;
  logic [SHIFT_W-1:0]         cmd_shift_next;
  logic [1:0]                 op_code;
  logic [CMD_ADDR_BITS-1:0]   cmd_addr;
  logic [1:0]                 sub_op;
  logic [mse_pkg::BYTE_W-1:0] byte_next;
  logic                       cmd_done;
  logic                       write_commit;
  logic                       fetch;

  always_comb begin
    cs_rise  = req.go && item.command == mse_pkg::CMD_CHIP_SELECT
               && item.pin_level && !cs_level;
    cs_fall  = req.go && item.command == mse_pkg::CMD_CHIP_SELECT
               && !item.pin_level && cs_level;
    clk_rise = req.go && item.command == mse_pkg::CMD_CLOCK
               && item.pin_level && !clk_level;

    cmd_shift_next = {op_shift[SHIFT_W-2:0], din_level};
    op_code        = cmd_shift_next[SHIFT_W-1:SHIFT_W-2];
    cmd_addr       = cmd_shift_next[CMD_ADDR_BITS-1:0];
    sub_op         = cmd_addr[CMD_ADDR_BITS-1:CMD_ADDR_BITS-2];
    byte_next      = {data_shift[mse_pkg::BYTE_W-2:0], din_level};

    cmd_done     = clk_rise && phase == PH_CMD && bit_counter == CMD_LAST;
    write_commit = clk_rise && phase == PH_DATA && bit_counter == BYTE_LAST && !locked;
    fetch        = clk_rise && phase == PH_READ && bit_counter == '0;
  end

  // Store write port: fill sweep, preload or committed write byte
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = mse_pkg::ERASED_BYTE;
    if (seq == SEQ_CLEAR) begin
      mem_we = 1'b1;
    end else if (req.go && item.command == mse_pkg::CMD_PRELOAD) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(item.load_address);
      mem_wdata = item.load_data;
    end else if (write_commit) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(cur_addr);
      mem_wdata = byte_next;
    end
  end

  assign mem_raddr = IDX_W'(cur_addr);

  assign status.idle        = seq == SEQ_IDLE && !res_pending;
  assign status.res_pending = res_pending;
  assign status.dout        = !(phase == PH_READ && !data_shift[mse_pkg::BYTE_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= SEQ_CLEAR;
      phase       <= PH_RESET;
      cs_level    <= 1'b0;
      clk_level   <= 1'b0;
      din_level   <= 1'b0;
      locked      <= 1'b0;
      res_pending <= 1'b0;
      bit_counter <= '0;
      op_shift    <= '0;
      data_shift  <= '0;
      cur_addr    <= '0;
      clr_idx     <= '0;
    end else begin
      if (req.taken) begin
        res_pending <= 1'b0;
      end
      case (seq)
        SEQ_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == LAST_IDX) begin
            seq <= SEQ_IDLE;
          end
        end
        SEQ_LOAD: begin
          data_shift  <= mem_rdata;
          res_pending <= 1'b1;
          seq         <= SEQ_IDLE;
        end
        SEQ_IDLE: begin
          if (req.go) begin
            // hold the result back while a read fetch is outstanding
            res_pending <= !fetch;
            case (item.command)
              mse_pkg::CMD_DATA_IN:     din_level <= item.pin_level;
              mse_pkg::CMD_CHIP_SELECT: cs_level  <= item.pin_level;
              mse_pkg::CMD_CLOCK:       clk_level <= item.pin_level;
              default: ;
            endcase

            if (cs_fall) begin
              phase <= PH_RESET;
            end else if (cs_rise) begin
              if (phase == PH_RESET) begin
                phase <= PH_START;
              end
            end else if (clk_rise) begin
              case (phase)
                PH_START: begin
                  if (din_level) begin
                    op_shift    <= '0;
                    bit_counter <= '0;
                    phase       <= PH_CMD;
                  end
                end
                PH_CMD: begin
                  op_shift    <= cmd_shift_next;
                  bit_counter <= cmd_done ? '0 : bit_counter + CNT_W'(1);
                  if (cmd_done) begin
                    if (op_code == mse_pkg::OPC_EXT) begin
                      cur_addr <= '0;
                      case (sub_op)
                        mse_pkg::SUB_LOCK: begin
                          locked <= 1'b1;
                          phase  <= PH_RESET;
                        end
                        mse_pkg::SUB_UNLOCK: begin
                          locked <= 1'b0;
                          phase  <= PH_RESET;
                        end
                        mse_pkg::SUB_ERASE: begin
                          if (locked) begin
                            phase <= PH_RESET;
                          end else begin
                            phase   <= PH_DONE;
                            seq     <= SEQ_CLEAR;
                            clr_idx <= '0;
                          end
                        end
                        default: phase <= PH_RESET;
                      endcase
                    end else begin
                      cur_addr   <= ADDR_BITS'(cmd_addr);
                      data_shift <= '0;
                      phase      <= (op_code == mse_pkg::OPC_READ) ? PH_READ : PH_DATA;
                    end
                  end
                end
                PH_READ: begin
                  bit_counter <= CNT_W'(3'(bit_counter[2:0] + 3'd1));
                  if (bit_counter == '0) begin
                    // fetch the next byte; the shift loads it in the following cycle
                    cur_addr <= cur_addr + ADDR_BITS'(1);
                    seq      <= SEQ_LOAD;
                  end else begin
                    data_shift <= {data_shift[mse_pkg::BYTE_W-2:0], 1'b1};
                  end
                end
                PH_DATA: begin
                  data_shift  <= byte_next;
                  bit_counter <= bit_counter + CNT_W'(1);
                  if (bit_counter == BYTE_LAST) begin
                    phase <= locked ? PH_RESET : PH_DONE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: seq <= SEQ_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/microwire_serial_eeprom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microwire_serial_eeprom: Microwire (three-wire) serial EEPROM of bytes
// Pin-level model: each transaction changes one pin or preloads one byte,
// and returns the data-out level after that change.
// ----------------------------------------------------------------------------
// Each input transaction changes the chip select, clock or data-in pin, or
// preloads one byte of the store; each returns one result carrying the
// data-out pin level after it. An accepted item sets the pending result of
// the controller, which then moves into the output register; when a read
// fetches the next byte, the registered read data of the byte store is
// loaded into the shift register first. The next item is accepted only once
// the result has left the controller. Erase-all, and the fill pass right
// after reset, write 0xFF into the store one entry per cycle over all DEPTH
// entries (128 at the default), during which no item is accepted. The output
// register frees the controller, so the next item may be accepted while a
// result still waits on out_ready. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module microwire_serial_eeprom #(
  parameter int ADDR_BITS     = mse_pkg::DEFAULT_ADDR_BITS,
  parameter int CMD_ADDR_BITS = mse_pkg::DEFAULT_CMD_ADDR_BITS,
  parameter int DEPTH         = mse_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic                              pin_level,
  input  logic [mse_pkg::LOAD_ADDR_W-1:0]   load_address,
  input  logic [mse_pkg::BYTE_W-1:0]        load_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              data_out
);

  localparam int IDX_W = $clog2(DEPTH);

  mse_pkg::item_t        item;
  mse_pkg::ctrl_req_t    req;
  mse_pkg::ctrl_status_t status;

  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [mse_pkg::BYTE_W-1:0] mem_wdata;
  logic [IDX_W-1:0]           mem_raddr;
  logic [mse_pkg::BYTE_W-1:0] mem_rdata;
  logic                       take;

  // Pack the pin transaction for the controller
  assign item.command      = mse_pkg::cmd_t'(command);
  assign item.pin_level    = pin_level;
  assign item.load_address = load_address;
  assign item.load_data    = load_data;

  // Accept only when the controller has finished and delivered the last item
  assign in_ready = status.idle;

  // Move a finished result into the output register when it is empty or
  // being drained this cycle
  assign take      = status.res_pending && (!out_valid || out_ready);
  assign req.go    = in_valid && in_ready;
  assign req.taken = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
      data_out  <= status.dout;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  mse_ctrl #(
    .ADDR_BITS     (ADDR_BITS),
    .CMD_ADDR_BITS (CMD_ADDR_BITS),
    .DEPTH         (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .req       (req),
    .status    (status),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  mse_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule

@@ tb/tb_microwire_serial_eeprom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_microwire_serial_eeprom: self-checking bench for the Microwire EEPROM
// Feeds pin-change and preload transactions through a valid/ready driver,
// predicts the data-out level of each one with a behavioral copy of the
// controller and byte store, and compares every returned transaction in order.
// ----------------------------------------------------------------------------
module tb_microwire_serial_eeprom;

  localparam int AW         = mse_pkg::DEFAULT_ADDR_BITS;
  localparam int CA         = mse_pkg::DEFAULT_CMD_ADDR_BITS;
  localparam int MEM_DEPTH  = mse_pkg::DEFAULT_DEPTH;
  localparam int RAND_ITEMS = 120;
  localparam int LONG_HOLD  = 300;
  localparam int END_WAIT   = 20;

  // Controller phases and decoded commands of the predictor
  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_OPCODE, PH_READ, PH_WRITE, PH_DONE
  } mw_phase_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_READ, OP_WRITE, OP_LOCK, OP_UNLOCK, OP_ERASE
  } mw_op_e;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      command = mse_pkg::CMD_DATA_IN;
  logic                            pin_level = 1'b0;
  logic [mse_pkg::LOAD_ADDR_W-1:0] load_address = '0;
  logic [mse_pkg::BYTE_W-1:0]      load_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            data_out;

  microwire_serial_eeprom uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .pin_level    (pin_level),
    .load_address (load_address),
    .load_data    (load_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_out     (data_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: pins, controller and byte store as seen from the pins
  // --------------------------------------------------------------------------
  logic                       pin_cs, pin_clk, pin_din;
  mw_phase_e                  ctl_phase;
  logic                       lock_on;
  int                         bit_cnt;
  logic [CA+1:0]              cmd_sr;
  logic [7:0]                 data_sr;
  logic [AW-1:0]              rd_addr;
  logic [mse_pkg::BYTE_W-1:0] mem [MEM_DEPTH];

  function automatic void model_reset();
    pin_cs    = 1'b0;
    pin_clk   = 1'b0;
    pin_din   = 1'b0;
    ctl_phase = PH_IDLE;
    lock_on   = 1'b0;
    bit_cnt   = 0;
    cmd_sr    = '0;
    data_sr   = '0;
    rd_addr   = '0;
    foreach (mem[i]) mem[i] = mse_pkg::ERASED_BYTE;
  endfunction

  // Decode the opcode and address once all command bits are in
  function automatic void run_opcode();
    logic [1:0]    opc;
    logic [CA-1:0] a;
    mw_op_e        dop;
    opc = cmd_sr[CA+1:CA];
    a   = cmd_sr[CA-1:0];
    dop = OP_NONE;
    if (opc == mse_pkg::OPC_EXT) begin
      case (a[CA-1:CA-2])
        mse_pkg::SUB_LOCK:   dop = OP_LOCK;
        mse_pkg::SUB_ERASE:  dop = OP_ERASE;
        mse_pkg::SUB_UNLOCK: dop = OP_UNLOCK;
        default:             dop = OP_NONE;
      endcase
      a = '0;
    end else if (opc == mse_pkg::OPC_READ) begin
      dop = OP_READ;
    end else begin
      dop = OP_WRITE;
    end
    rd_addr = AW'(a);
    bit_cnt = 0;
    case (dop)
      OP_READ: begin
        data_sr   = '0;
        ctl_phase = PH_READ;
      end
      OP_WRITE: begin
        data_sr   = '0;
        ctl_phase = PH_WRITE;
      end
      OP_LOCK: begin
        lock_on   = 1'b1;
        ctl_phase = PH_IDLE;
      end
      OP_UNLOCK: begin
        lock_on   = 1'b0;
        ctl_phase = PH_IDLE;
      end
      OP_ERASE: begin
        if (lock_on) begin
          ctl_phase = PH_IDLE;
        end else begin
          foreach (mem[i]) mem[i] = mse_pkg::ERASED_BYTE;
          ctl_phase = PH_DONE;
        end
      end
      default: ctl_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void clock_rise();
    case (ctl_phase)
      PH_START: begin
        if (pin_din) begin
          cmd_sr    = '0;
          bit_cnt   = 0;
          ctl_phase = PH_OPCODE;
        end
      end
      PH_OPCODE: begin
        cmd_sr  = {cmd_sr[CA:0], pin_din};
        bit_cnt = bit_cnt + 1;
        if (bit_cnt >= CA + 2) run_opcode();
      end
      PH_READ: begin
        // Fetch a fresh byte whenever the bit count wraps to zero, shift in ones between fetches
        if (bit_cnt == 0) begin
          data_sr = mem[rd_addr];
          rd_addr = rd_addr + 1'b1;
        end else begin
          data_sr = {data_sr[6:0], 1'b1};
        end
        bit_cnt = (bit_cnt + 1) % 8;
      end
      PH_WRITE: begin
        data_sr = {data_sr[6:0], pin_din};
        bit_cnt = bit_cnt + 1;
        if (bit_cnt >= 8) begin
          if (lock_on) begin
            ctl_phase = PH_IDLE;
          end else begin
            mem[rd_addr] = data_sr;
            ctl_phase    = PH_DONE;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Apply one transaction to the predictor and return the data-out level
  function automatic logic eeprom_apply(logic [1:0] cmd, logic lvl,
                                        logic [mse_pkg::LOAD_ADDR_W-1:0] la,
                                        logic [mse_pkg::BYTE_W-1:0] ld);
    case (mse_pkg::cmd_t'(cmd))
      mse_pkg::CMD_DATA_IN: pin_din = lvl;
      mse_pkg::CMD_CHIP_SELECT: begin
        if (lvl != pin_cs) begin
          pin_cs = lvl;
          if (!lvl) begin
            ctl_phase = PH_IDLE;
          end else if (ctl_phase == PH_IDLE) begin
            ctl_phase = PH_START;
          end
        end
      end
      mse_pkg::CMD_CLOCK: begin
        if (lvl != pin_clk) begin
          pin_clk = lvl;
          if (lvl) clock_rise();
        end
      end
      default: mem[la] = ld;
    endcase
    return !(ctl_phase == PH_READ && !data_sr[7]);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation: pending transactions and the pin levels they leave
  // --------------------------------------------------------------------------
  mse_pkg::item_t pin_queue[$];
  logic           dout_expected[$];
  int             queued = 0;
  logic           gen_cs = 1'b0, gen_clk = 1'b0, gen_din = 1'b0;

  task automatic put(mse_pkg::cmd_t c, logic lvl);
    mse_pkg::item_t it;
    it.command      = c;
    it.pin_level    = lvl;
    it.load_address = mse_pkg::LOAD_ADDR_W'($urandom);
    it.load_data    = mse_pkg::BYTE_W'($urandom);
    pin_queue.push_back(it);
    queued++;
    case (c)
      mse_pkg::CMD_DATA_IN:     gen_din = lvl;
      mse_pkg::CMD_CHIP_SELECT: gen_cs  = lvl;
      mse_pkg::CMD_CLOCK:       gen_clk = lvl;
      default: ;
    endcase
  endtask

  task automatic preload(logic [mse_pkg::LOAD_ADDR_W-1:0] a,
                         logic [mse_pkg::BYTE_W-1:0] d);
    mse_pkg::item_t it;
    it.command      = mse_pkg::CMD_PRELOAD;
    it.pin_level    = 1'($urandom);
    it.load_address = a;
    it.load_data    = d;
    pin_queue.push_back(it);
    queued++;
  endtask

  // One serial bit: set data-in if it differs, then a full clock pulse
  task automatic clock_in(logic b);
    if (gen_din != b) put(mse_pkg::CMD_DATA_IN, b);
    if (gen_clk) put(mse_pkg::CMD_CLOCK, 1'b0);
    put(mse_pkg::CMD_CLOCK, 1'b1);
    put(mse_pkg::CMD_CLOCK, 1'b0);
  endtask

  task automatic select();
    if (gen_cs) put(mse_pkg::CMD_CHIP_SELECT, 1'b0);
    put(mse_pkg::CMD_CHIP_SELECT, 1'b1);
  endtask

  // Select, optional idle clocks, start bit, opcode, then address MSB first
  task automatic send_command(logic [1:0] opc, logic [CA-1:0] a);
    select();
    repeat ($urandom_range(0, 2)) clock_in(1'b0);
    clock_in(1'b1);
    for (int i = 1; i >= 0; i--) clock_in(opc[i]);
    for (int i = CA - 1; i >= 0; i--) clock_in(a[i]);
  endtask

  task automatic read_seq(logic [CA-1:0] a, int nbits);
    send_command(mse_pkg::OPC_READ, a);
    repeat (nbits) clock_in(1'($urandom));
    put(mse_pkg::CMD_CHIP_SELECT, 1'b0);
  endtask

  task automatic write_seq(logic [CA-1:0] a, logic [7:0] d, int extra);
    send_command($urandom_range(0, 1) ? mse_pkg::OPC_WRITE_A : mse_pkg::OPC_WRITE_B, a);
    for (int i = 7; i >= 0; i--) clock_in(d[i]);
    repeat (extra) clock_in(1'($urandom));
    put(mse_pkg::CMD_CHIP_SELECT, 1'b0);
  endtask

  task automatic special_seq(logic [1:0] sub);
    send_command(mse_pkg::OPC_EXT, {sub, (CA - 2)'($urandom)});
    repeat ($urandom_range(0, 2)) clock_in(1'($urandom));
    put(mse_pkg::CMD_CHIP_SELECT, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Idle draws: a drawn idle wait per transaction, with bursts of no idling
  // --------------------------------------------------------------------------
  int tx_burst = 0;
  int rx_burst = 0;

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: hold each transaction until accepted, predict it on acceptance
  // --------------------------------------------------------------------------
  int tx_wait = 0;

  always @(posedge clk) begin : driver
    mse_pkg::item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        dout_expected.push_back(eeprom_apply(command, pin_level, load_address,
                                             load_data));
      end
      // Advance only when the slot is free; otherwise hold valid and payload
      if (!in_valid || in_ready) begin
        if (tx_wait != 0) begin
          tx_wait  <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (pin_queue.size() != 0) begin
          nxt = pin_queue.pop_front();
          command      <= nxt.command;
          pin_level    <= nxt.pin_level;
          load_address <= nxt.load_address;
          load_data    <= nxt.load_data;
          in_valid     <= 1'b1;
          tx_wait      <= draw_wait(tx_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here and started by the stimulus
  // --------------------------------------------------------------------------
  logic hold_trigger = 1'b0;
  int   hold_left = 0;
  logic long_hold;

  always @(posedge clk) begin : hold_counter
    if (rst) begin
      hold_left <= 0;
    end else if (hold_trigger) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  assign long_hold = (hold_left != 0);

  // --------------------------------------------------------------------------
  // Monitor: compare each returned transaction with the oldest prediction
  // --------------------------------------------------------------------------
  int mismatch_count = 0;
  int result_count = 0;
  int rx_wait = 0;

  always @(posedge clk) begin : monitor
    logic want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (dout_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected result, data_out=%0b at %0t", data_out, $time);
        end else begin
          want = dout_expected.pop_front();
          if (data_out !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: result %0d data_out expected %0b actual %0b at %0t",
                       result_count, want, data_out, $time);
          end
        end
        result_count++;
        rx_wait = draw_wait(rx_burst);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0) && !long_hold;
    end
  end

  // Hold the sender until every queued transaction has come back
  task automatic wait_drained();
    while (pin_queue.size() != 0 || in_valid || dout_expected.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int base;
    int pick;
    logic [CA-1:0] a;
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, unchanged levels, ignored edges, aborts
    preload('0, 8'h00);
    preload('1, 8'hFF);
    preload(7'd1, 8'h80);
    put(mse_pkg::CMD_CHIP_SELECT, 1'b0);     // unchanged level
    put(mse_pkg::CMD_CLOCK, 1'b0);
    put(mse_pkg::CMD_DATA_IN, 1'b0);
    put(mse_pkg::CMD_DATA_IN, 1'b1);
    put(mse_pkg::CMD_CLOCK, 1'b1);           // rise while deselected
    put(mse_pkg::CMD_CLOCK, 1'b0);
    put(mse_pkg::CMD_CHIP_SELECT, 1'b1);
    put(mse_pkg::CMD_CHIP_SELECT, 1'b1);
    put(mse_pkg::CMD_DATA_IN, 1'b0);
    put(mse_pkg::CMD_CLOCK, 1'b1);           // no start bit yet
    put(mse_pkg::CMD_CLOCK, 1'b0);
    put(mse_pkg::CMD_DATA_IN, 1'b1);
    put(mse_pkg::CMD_CLOCK, 1'b1);           // start bit
    preload(7'd64, 8'hA5);                   // preload mid-command leaves pins alone
    put(mse_pkg::CMD_CLOCK, 1'b0);
    put(mse_pkg::CMD_CLOCK, 1'b1);
    put(mse_pkg::CMD_CHIP_SELECT, 1'b0);     // drop select in the middle of a command
    put(mse_pkg::CMD_CLOCK, 1'b0);
    wait_drained();

    // Every command at least once: read wrap, lock refusals, erase, invalid opcode
    write_seq('1, 8'h3C, 0);
    read_seq('1, 9);
    special_seq(mse_pkg::SUB_LOCK);
    write_seq(7'd5, 8'h00, 2);
    special_seq(mse_pkg::SUB_ERASE);
    read_seq(7'd5, 8);
    special_seq(mse_pkg::SUB_UNLOCK);
    special_seq(mse_pkg::SUB_INVALID);
    special_seq(mse_pkg::SUB_ERASE);
    read_seq('1, 1);
    wait_drained();

    // Random: mostly well-formed commands, some noise and broken sequences
    base = queued;
    while (queued - base < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      a    = CA'($urandom);
      if (pick < 30) begin
        if ($urandom_range(0, 3) == 0) begin
          preload(a, mse_pkg::BYTE_W'($urandom));
          preload(a + 1'b1, mse_pkg::BYTE_W'($urandom));
        end
        read_seq(a, ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 24));
      end else if (pick < 55) begin
        write_seq(a, 8'($urandom), $urandom_range(0, 2));
      end else if (pick < 62) begin
        special_seq(mse_pkg::SUB_LOCK);
      end else if (pick < 72) begin
        special_seq(mse_pkg::SUB_UNLOCK);
      end else if (pick < 75) begin
        special_seq(mse_pkg::SUB_ERASE);
      end else if (pick < 79) begin
        special_seq(mse_pkg::SUB_INVALID);
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) preload(a, mse_pkg::BYTE_W'($urandom));
          else put(mse_pkg::cmd_t'($urandom_range(0, 2)), 1'($urandom));
        end
      end else if (pick < 95) begin
        // Broken command: select, start bit, a few bits, then drop select
        select();
        clock_in(1'b1);
        repeat ($urandom_range(0, 8)) clock_in(1'($urandom));
        put(mse_pkg::CMD_CHIP_SELECT, 1'b0);
      end else begin
        preload(a, mse_pkg::BYTE_W'($urandom));
      end
    end

    // Start the long hold-off with the whole random run queued behind it
    hold_trigger = 1'b1;
    @(negedge clk);
    hold_trigger = 1'b0;

    wait_drained();
    repeat (END_WAIT) @(posedge clk);
    if (dout_expected.size() != 0) begin
      $display("ERROR: %0d results never arrived", dout_expected.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
